>>> rtl/psc_pkg.sv
// Shared types and constants for the polymorphism site classifier.
`timescale 1ns / 1ps

package psc_pkg;

   localparam int NumCounters = 9;
   localparam int OutCountBits = 16;

   // counter slots
   localparam int IdxBial   = 0;
   localparam int IdxMulti  = 1;
   localparam int IdxFdiff  = 2;
   localparam int IdxFout   = 3;
   localparam int IdxExa    = 4;
   localparam int IdxExb    = 5;
   localparam int IdxShared = 6;
   localparam int IdxSega   = 7;
   localparam int IdxSegb   = 8;

   typedef enum logic [2:0] {
      CLASS_INVARIANT = 3'd0,
      CLASS_FIXED_OUT = 3'd1,
      CLASS_FIXED_DIFF = 3'd2,
      CLASS_EXCL_A = 3'd3,
      CLASS_EXCL_B = 3'd4,
      CLASS_SHARED = 3'd5,
      CLASS_MULTI = 3'd6
   } class_type;

   typedef enum logic [1:0] {
      KINDS_NONE = 2'd0,
      KINDS_ONE = 2'd1,
      KINDS_TWO = 2'd2,
      KINDS_MORE = 2'd3
   } kinds_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      kinds_type  kinds;
   } allele_type;

   localparam int AddrBits = 3;
   localparam logic [0:0] RegHapA = 1'b0;
   localparam logic [0:0] RegHapB = 1'b1;

endpackage

>>> rtl/polymorphism_site_classifier.sv
// Top level: streams alignment columns and classifies each site at its outgroup base.
// A result is registered and appears on rsp_ in the cycle after its outgroup word is taken.
// Throughput: one word per cycle while the result stream is not stalled; all tracking and counting is one pass of logic
// between the column state and the result register.
// req_tready stays high while the result register is empty or being drained.
// Sync active-high reset clears column state and counters, sets both haplotype counts to 2.
`timescale 1ns / 1ps

module polymorphism_site_classifier #(
   parameter int MAX_HAPLOTYPES = 256,
   parameter int COUNTER_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] base
   input  logic         req_tuser,   // [0] new_locus
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] biallelic, [31:16] multiallelic, [47:32] fixed_diff,
   // [63:48] fixed_outgroup, [79:64] excl_a, [95:80] excl_b,
   // [111:96] shared, [127:112] segregating_a, [143:128] segregating_b
   output logic [143:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // [2:0] site_class
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [psc_pkg::AddrBits-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int PosW = $clog2(2 * MAX_HAPLOTYPES + 1);
   localparam int EffW = (PosW > 9) ? PosW : 9;
   localparam logic [EffW-1:0] MaxHaps = EffW'(MAX_HAPLOTYPES);
   localparam logic [COUNTER_BITS-1:0] CntTop = '1;

   logic [8:0] hap_a_ff, hap_a_in;
   logic [8:0] hap_b_ff, hap_b_in;
   logic [PosW-1:0] pos_ff, pos_in;
   psc_pkg::allele_type a_ff, a_in, b_ff, b_in;
   logic [COUNTER_BITS-1:0] cnt_ff [psc_pkg::NumCounters];
   logic [COUNTER_BITS-1:0] cnt_in [psc_pkg::NumCounters];
   logic rsp_valid_ff, rsp_valid_in;
   logic [143:0] rsp_data_ff, rsp_data_in;
   psc_pkg::class_type rsp_class_ff, rsp_class_in;

   logic [EffW-1:0] eff_a_wide, eff_b_wide;
   logic [PosW-1:0] eff_a, eff_b, eff_sum;
   logic accept, in_a, in_b, is_out, csr_write;
   psc_pkg::class_type cls;
   logic [psc_pkg::NumCounters-1:0] bump;

   function automatic psc_pkg::allele_type track(input psc_pkg::allele_type cur,
                                                 input logic [7:0] b);
      psc_pkg::allele_type nxt;
      nxt = cur;
      case (cur.kinds)
         psc_pkg::KINDS_NONE: begin
            nxt.first = b;
            nxt.kinds = psc_pkg::KINDS_ONE;
         end
         psc_pkg::KINDS_ONE: begin
            if (b != cur.first) begin
               nxt.second = b;
               nxt.kinds = psc_pkg::KINDS_TWO;
            end
         end
         psc_pkg::KINDS_TWO: begin
            if (b != cur.first && b != cur.second) nxt.kinds = psc_pkg::KINDS_MORE;
         end
         default: nxt = cur;
      endcase
      return nxt;
   endfunction

   // register port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   always_comb begin
      hap_a_in = hap_a_ff;
      hap_b_in = hap_b_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            psc_pkg::RegHapA: hap_a_in = csr_pwdata[8:0];
            psc_pkg::RegHapB: hap_b_in = csr_pwdata[8:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr[2])
         psc_pkg::RegHapA: csr_prdata = {23'd0, hap_a_ff};
         psc_pkg::RegHapB: csr_prdata = {23'd0, hap_b_ff};
         default: csr_prdata = '0;
      endcase
   end

   // zero acts as one, large values clamp to the configured maximum
   always_comb begin
      eff_a_wide = EffW'(hap_a_ff);
      eff_b_wide = EffW'(hap_b_ff);
      if (eff_a_wide == '0) eff_a_wide = EffW'(1);
      else if (eff_a_wide > MaxHaps) eff_a_wide = MaxHaps;
      if (eff_b_wide == '0) eff_b_wide = EffW'(1);
      else if (eff_b_wide > MaxHaps) eff_b_wide = MaxHaps;
   end
   assign eff_a = eff_a_wide[PosW-1:0];
   assign eff_b = eff_b_wide[PosW-1:0];
   assign eff_sum = eff_a + eff_b;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept = req_tvalid & req_tready;
   assign in_a = pos_ff < eff_a;
   assign in_b = ~in_a & (pos_ff < eff_sum);
   assign is_out = ~in_a & ~in_b;

   // classification of the gathered column against the outgroup base
   always_comb begin
      logic [1:0] ak, bk;
      logic [7:0] a1, a2, b1, b2, o;
      ak = (a_ff.kinds == psc_pkg::KINDS_NONE) ? 2'd1 : a_ff.kinds;
      bk = (b_ff.kinds == psc_pkg::KINDS_NONE) ? 2'd1 : b_ff.kinds;
      a1 = a_ff.first;
      a2 = a_ff.second;
      b1 = b_ff.first;
      b2 = b_ff.second;
      o = req_tdata;
      cls = psc_pkg::CLASS_MULTI;
      if (ak == psc_pkg::KINDS_MORE || bk == psc_pkg::KINDS_MORE) begin
         cls = psc_pkg::CLASS_MULTI;
      end else if (ak == psc_pkg::KINDS_ONE && bk == psc_pkg::KINDS_ONE) begin
         if (a1 == b1) begin
            cls = (o == a1) ? psc_pkg::CLASS_INVARIANT : psc_pkg::CLASS_FIXED_OUT;
         end else if (o == a1 || o == b1) begin
            cls = psc_pkg::CLASS_FIXED_DIFF;
         end
      end else if (ak == psc_pkg::KINDS_ONE) begin
         if ((a1 == b1 || a1 == b2) && (o == b1 || o == b2)) cls = psc_pkg::CLASS_EXCL_B;
      end else if (bk == psc_pkg::KINDS_ONE) begin
         if ((b1 == a1 || b1 == a2) && (o == a1 || o == a2)) cls = psc_pkg::CLASS_EXCL_A;
      end else if (((a1 == b1 && a2 == b2) || (a1 == b2 && a2 == b1))
                   && (o == a1 || o == a2)) begin
         cls = psc_pkg::CLASS_SHARED;
      end
   end

   always_comb begin
      bump = '0;
      case (cls)
         psc_pkg::CLASS_FIXED_OUT: bump[psc_pkg::IdxFout] = 1'b1;
         psc_pkg::CLASS_FIXED_DIFF: bump[psc_pkg::IdxFdiff] = 1'b1;
         psc_pkg::CLASS_EXCL_A: bump[psc_pkg::IdxExa] = 1'b1;
         psc_pkg::CLASS_EXCL_B: bump[psc_pkg::IdxExb] = 1'b1;
         psc_pkg::CLASS_SHARED: bump[psc_pkg::IdxShared] = 1'b1;
         psc_pkg::CLASS_MULTI: bump[psc_pkg::IdxMulti] = 1'b1;
         default: ;
      endcase
      bump[psc_pkg::IdxBial] = (cls != psc_pkg::CLASS_INVARIANT)
                               && (cls != psc_pkg::CLASS_MULTI);
      bump[psc_pkg::IdxSega] = a_ff.kinds[1];
      bump[psc_pkg::IdxSegb] = b_ff.kinds[1];
   end

   // column state and counters
   always_comb begin
      pos_in = pos_ff;
      a_in = a_ff;
      b_in = b_ff;
      for (int i = 0; i < psc_pkg::NumCounters; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (accept && req_tuser) cnt_in[i] = '0;
         if (accept && is_out && bump[i] && cnt_in[i] != CntTop) cnt_in[i] = cnt_in[i] + 1'b1;
      end
      if (accept) begin
         if (in_a) begin
            a_in = track(a_ff, req_tdata);
            pos_in = pos_ff + 1'b1;
         end else if (in_b) begin
            b_in = track(b_ff, req_tdata);
            pos_in = pos_ff + 1'b1;
         end else begin
            pos_in = '0;
            a_in = '0;
            b_in = '0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_class_in = rsp_class_ff;
      if (accept && is_out) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = cls;
         for (int i = 0; i < psc_pkg::NumCounters; i++) begin
            rsp_data_in[i*psc_pkg::OutCountBits +: psc_pkg::OutCountBits] =
               psc_pkg::OutCountBits'(cnt_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hap_a_ff <= 9'd2;
         hap_b_ff <= 9'd2;
         pos_ff <= '0;
         a_ff <= '0;
         b_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < psc_pkg::NumCounters; i++) cnt_ff[i] <= '0;
      end else begin
         hap_a_ff <= hap_a_in;
         hap_b_ff <= hap_b_in;
         pos_ff <= pos_in;
         a_ff <= a_in;
         b_ff <= b_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < psc_pkg::NumCounters; i++) cnt_ff[i] <= cnt_in[i];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_class_ff;

endmodule
